// ----- src/bsrm_pkg.sv -----
// ----------------------------------------------------------------------------
// bsrm_pkg
// Shared types and constants of the battery sag and rest monitor: item and
// result words, configuration set, register indexes and pump phase codes.
// ----------------------------------------------------------------------------
package bsrm_pkg;

    // Fixed field widths of the channel words
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned PHASE_W     = 2;
    localparam int unsigned ADC_IN_W    = 12;
    localparam int unsigned LEVEL_OUT_W = 20;
    localparam int unsigned IVAL_W      = 16;
    localparam int unsigned GAIN_W      = 16;

    // APB geometry: four registers in 32-bit words at byte offsets 0, 4, 8, 12
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;

    // Pump phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_UNKNOWN = 2'd1;
    localparam logic [PHASE_W-1:0] PH_CRANK   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_OTHER   = 2'd3;

    // Register indexes
    typedef enum logic [1:0] {
        REG_CRANK_INTERVAL  = 2'd0,
        REG_SAMPLE_INTERVAL = 2'd1,
        REG_REST_SETTLE     = 2'd2,
        REG_SMOOTHING_GAIN  = 2'd3
    } reg_idx_t;

    // Register reset values
    localparam logic [IVAL_W-1:0] CRANK_INTERVAL_RST  = 16'd20;
    localparam logic [IVAL_W-1:0] SAMPLE_INTERVAL_RST = 16'd2000;
    localparam logic [TIME_W-1:0] REST_SETTLE_RST     = 32'd60000;
    localparam logic [GAIN_W-1:0] SMOOTHING_GAIN_RST  = 16'd6554;

    typedef struct packed {
        logic [IVAL_W-1:0] crank_interval_ms;
        logic [IVAL_W-1:0] sample_interval_ms;
        logic [TIME_W-1:0] rest_settle_ms;
        logic [GAIN_W-1:0] smoothing_gain;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]   now_ms;
        logic [PHASE_W-1:0]  pump_phase;
        logic                relays_active;
        logic [ADC_IN_W-1:0] adc_sample;
    } item_t;

    typedef struct packed {
        logic [LEVEL_OUT_W-1:0] live_level;
        logic [ADC_IN_W-1:0]    crank_minimum;
        logic [LEVEL_OUT_W-1:0] resting_level;
        logic                   resting_valid;
        logic                   sampled;
    } result_t;

endpackage

// ----- src/bsrm_ifs.sv -----
// ----------------------------------------------------------------------------
// bsrm channel interfaces
// Valid/ready channels for tick words into the monitor and result words out.
// ----------------------------------------------------------------------------
interface bsrm_item_if;
    logic              valid;
    logic              ready;
    bsrm_pkg::item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsrm_result_if;
    logic              valid;
    logic              ready;
    bsrm_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/battery_sag_and_rest_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// battery_sag_and_rest_monitor_unit
// Top level: tick input register, monitor update, result register and APB
// configuration registers.
// ----------------------------------------------------------------------------
// Each accepted tick word produces exactly one result word. The block takes
// one tick per clock cycle, sustained, as long as result words are taken; a
// tick passes through the input register and then through the result
// register. Throughput is set by the single update stage between those two
// registers: one 20x16 multiply and an add for
// the moving average, in parallel with the time compares and the crank/rest
// bookkeeping. Monitor state commits at the edge where a tick moves from the
// input register into the result register, so the following tick already
// sees it. The input channel keeps accepting while a finished result waits on
// the output; only when both registers hold words does ready drop. Write the
// registers over APB only while no tick is in flight. ADC_BITS and FRAC_BITS
// set the width of the internal level (ADC_BITS + FRAC_BITS); the level fields
// on the result channel are 20 bits, and wider levels are cut to their low
// bits.
// ----------------------------------------------------------------------------
module battery_sag_and_rest_monitor_unit #(
    parameter int unsigned ADC_BITS  = 12,
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bsrm_item_if.sink                       item,
    bsrm_result_if.source                   result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bsrm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bsrm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bsrm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    bsrm_pkg::cfg_t    cfg;
    bsrm_pkg::item_t   in_data_reg;
    logic              in_valid_reg, in_valid_next;
    bsrm_pkg::result_t out_data_reg;
    logic              out_valid_reg, out_valid_next;
    bsrm_pkg::result_t core_result;
    logic              out_space;
    logic              advance;
    logic              accept;

    bsrm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bsrm_core #(
        .ADC_BITS  (ADC_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Move a tick forward when the result register is empty or being drained
    assign out_space  = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && out_space;
    assign item.ready = !in_valid_reg || out_space;
    assign accept     = item.valid && item.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on handshake, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= item.data;
        end
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

`ifndef SYNTHESIS
    a_stall_means_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !item.ready |-> (in_valid_reg && out_valid_reg)
    ) else $error("input stalled while a register is free");

    a_advance_fills_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg
    ) else $error("advanced tick did not reach the result register");

    a_rest_level_gated: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.resting_valid) |-> (out_data_reg.resting_level == '0)
    ) else $error("resting level shown while not valid");

    a_no_sample_no_move: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && !core_result.sampled) |=>
            (out_data_reg.live_level == $past(out_data_reg.live_level) ||
             !$past(out_valid_reg))
    ) else $error("live level changed on a tick without a sample");
`endif

endmodule

// ----- src/bsrm_cfg.sv -----
// ----------------------------------------------------------------------------
// bsrm_cfg
// APB register file holding the sampling intervals, settle time and gain.
// ----------------------------------------------------------------------------
module bsrm_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bsrm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bsrm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bsrm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output bsrm_pkg::cfg_t                      cfg
);

    bsrm_pkg::cfg_t     cfg_reg;
    bsrm_pkg::cfg_t     cfg_next;
    bsrm_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = bsrm_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                bsrm_pkg::REG_CRANK_INTERVAL:
                    cfg_next.crank_interval_ms  = pwdata[bsrm_pkg::IVAL_W-1:0];
                bsrm_pkg::REG_SAMPLE_INTERVAL:
                    cfg_next.sample_interval_ms = pwdata[bsrm_pkg::IVAL_W-1:0];
                bsrm_pkg::REG_REST_SETTLE:
                    cfg_next.rest_settle_ms     = pwdata[bsrm_pkg::TIME_W-1:0];
                bsrm_pkg::REG_SMOOTHING_GAIN:
                    cfg_next.smoothing_gain     = pwdata[bsrm_pkg::GAIN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bsrm_pkg::REG_CRANK_INTERVAL:
                prdata = bsrm_pkg::APB_DATA_W'(cfg_reg.crank_interval_ms);
            bsrm_pkg::REG_SAMPLE_INTERVAL:
                prdata = bsrm_pkg::APB_DATA_W'(cfg_reg.sample_interval_ms);
            bsrm_pkg::REG_REST_SETTLE:
                prdata = bsrm_pkg::APB_DATA_W'(cfg_reg.rest_settle_ms);
            bsrm_pkg::REG_SMOOTHING_GAIN:
                prdata = bsrm_pkg::APB_DATA_W'(cfg_reg.smoothing_gain);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crank_interval_ms  <= bsrm_pkg::CRANK_INTERVAL_RST;
            cfg_reg.sample_interval_ms <= bsrm_pkg::SAMPLE_INTERVAL_RST;
            cfg_reg.rest_settle_ms     <= bsrm_pkg::REST_SETTLE_RST;
            cfg_reg.smoothing_gain     <= bsrm_pkg::SMOOTHING_GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/bsrm_core.sv -----
// ----------------------------------------------------------------------------
// bsrm_core
// Monitor state and the per-tick update: sample gating, smoothing, crank
// minimum tracking and resting level management.
// ----------------------------------------------------------------------------
module bsrm_core #(
    parameter int unsigned ADC_BITS  = 12,
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  bsrm_pkg::item_t   item,
    input  bsrm_pkg::cfg_t    cfg,
    output bsrm_pkg::result_t result
);

    localparam int unsigned LEVEL_W = ADC_BITS + FRAC_BITS;
    localparam int unsigned RAW_W   = (ADC_BITS < bsrm_pkg::ADC_IN_W) ?
                                      ADC_BITS : bsrm_pkg::ADC_IN_W;
    localparam int unsigned TW      = bsrm_pkg::TIME_W;
    localparam int unsigned PROD_W  = LEVEL_W + bsrm_pkg::GAIN_W;

    logic [LEVEL_W-1:0] level_reg,      level_next;
    logic               primed_reg,     primed_next;
    logic               crank_reg,      crank_next;
    logic [RAW_W-1:0]   run_min_reg,    run_min_next;
    logic [RAW_W-1:0]   pub_min_reg,    pub_min_next;
    logic [LEVEL_W-1:0] rest_lvl_reg,   rest_lvl_next;
    logic               rest_flag_reg,  rest_flag_next;
    logic [TW-1:0]      last_smp_reg,   last_smp_next;
    logic [TW-1:0]      last_act_reg,   last_act_next;

    logic               in_crank;
    logic               activity;
    logic               take;
    logic [TW-1:0]      interval;
    logic [RAW_W-1:0]   raw;
    logic [LEVEL_W-1:0] reading;
    logic               rising;
    logic [LEVEL_W-1:0] diff;
    logic [PROD_W-1:0]  prod;
    logic [LEVEL_W-1:0] step;
    logic [LEVEL_W-1:0] ema;

    assign raw      = item.adc_sample[RAW_W-1:0];
    assign reading  = LEVEL_W'(raw) << FRAC_BITS;
    assign in_crank = (item.pump_phase == bsrm_pkg::PH_CRANK);
    assign activity = item.relays_active ||
                      (item.pump_phase inside {bsrm_pkg::PH_CRANK, bsrm_pkg::PH_OTHER});
    assign interval = in_crank ? TW'(cfg.crank_interval_ms) : TW'(cfg.sample_interval_ms);
    assign take     = ((item.now_ms - last_smp_reg) >= interval);

    // Moving average: floor on the way up, ceiling of the magnitude on the
    // way down, so the signed step always floors toward minus infinity.
    assign rising = (reading >= level_reg);
    assign diff   = rising ? (reading - level_reg) : (level_reg - reading);
    assign prod   = PROD_W'(diff) * PROD_W'(cfg.smoothing_gain);

    always_comb
    begin
        step = prod[PROD_W-1:bsrm_pkg::GAIN_W];
        if (!rising && (|prod[bsrm_pkg::GAIN_W-1:0]))
        begin
            step = step + LEVEL_W'(1);
        end
        ema = rising ? (level_reg + step) : (level_reg - step);
    end

    always_comb
    begin
        level_next     = level_reg;
        primed_next    = primed_reg;
        crank_next     = crank_reg;
        run_min_next   = run_min_reg;
        pub_min_next   = pub_min_reg;
        rest_lvl_next  = rest_lvl_reg;
        rest_flag_next = rest_flag_reg;
        last_smp_next  = last_smp_reg;
        last_act_next  = last_act_reg;

        // Publish the crank minimum as soon as the crank phase is left
        if (crank_reg && !in_crank)
        begin
            crank_next   = 1'b0;
            pub_min_next = run_min_reg;
        end

        if (take)
        begin
            last_smp_next = item.now_ms;
            primed_next   = 1'b1;
            level_next    = primed_reg ? ema : reading;

            if (in_crank)
            begin
                if (!crank_reg)
                begin
                    crank_next   = 1'b1;
                    run_min_next = raw;
                end
                else if (raw < run_min_reg)
                begin
                    run_min_next = raw;
                end
            end

            if (activity)
            begin
                last_act_next  = item.now_ms;
                rest_flag_next = 1'b0;
            end
            else if ((item.now_ms - last_act_reg) >= cfg.rest_settle_ms)
            begin
                rest_lvl_next  = level_next;
                rest_flag_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        result.live_level    = bsrm_pkg::LEVEL_OUT_W'(level_next);
        result.crank_minimum = bsrm_pkg::ADC_IN_W'(pub_min_next);
        result.resting_level = rest_flag_next ? bsrm_pkg::LEVEL_OUT_W'(rest_lvl_next) : '0;
        result.resting_valid = rest_flag_next;
        result.sampled       = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            primed_reg    <= 1'b0;
            crank_reg     <= 1'b0;
            run_min_reg   <= '0;
            pub_min_reg   <= '0;
            rest_lvl_reg  <= '0;
            rest_flag_reg <= 1'b0;
            last_smp_reg  <= '0;
            last_act_reg  <= '0;
        end
        else if (advance)
        begin
            level_reg     <= level_next;
            primed_reg    <= primed_next;
            crank_reg     <= crank_next;
            run_min_reg   <= run_min_next;
            pub_min_reg   <= pub_min_next;
            rest_lvl_reg  <= rest_lvl_next;
            rest_flag_reg <= rest_flag_next;
            last_smp_reg  <= last_smp_next;
            last_act_reg  <= last_act_next;
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Battery sag and rest monitor testbench
// Drives tick words into battery_sag_and_rest_monitor_unit through a paced
// valid/ready sender, programs the APB registers between traffic phases and
// checks every result word against a cycle-free model of the monitor kept in
// this file. Covers directed edge ticks, reset and extreme register settings,
// zero intervals, time wrap and long random pump sessions with noise.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAC_W         = 8;
    localparam int unsigned PROD_W         = bsrm_pkg::LEVEL_OUT_W + bsrm_pkg::GAIN_W;
    localparam int          LATENCY_SLACK  = 4;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          PHASE_ITEMS    = 320;

    // Kinds of pump session segment used to shape the random traffic
    typedef enum logic [1:0] {
        SEG_IDLE,
        SEG_CRANK,
        SEG_OTHER,
        SEG_UNKNOWN
    } segment_t;

    // Stall patterns of the result receiver
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_BURST_STALL
    } rx_mode_t;

    logic clk;
    logic rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bsrm_pkg::APB_ADDR_W-1:0] paddr;
    logic [bsrm_pkg::APB_DATA_W-1:0] pwdata;
    logic [bsrm_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    bsrm_item_if   item_ch ();
    bsrm_result_if result_ch ();

    battery_sag_and_rest_monitor_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Shadow of the monitor: register copy and state, advanced once per
    // accepted tick word in acceptance order.
    // ------------------------------------------------------------------------
    bsrm_pkg::cfg_t                   regs;
    logic [bsrm_pkg::LEVEL_OUT_W-1:0] mon_level;
    logic                             mon_primed;
    logic                             mon_crank_on;
    logic [bsrm_pkg::ADC_IN_W-1:0]    mon_crank_low;
    logic [bsrm_pkg::ADC_IN_W-1:0]    mon_crank_pub;
    logic [bsrm_pkg::LEVEL_OUT_W-1:0] mon_rest_level;
    logic                             mon_rest_ok;
    logic [bsrm_pkg::TIME_W-1:0]      mon_last_sample;
    logic [bsrm_pkg::TIME_W-1:0]      mon_last_activity;

    // Result words still owed by the block, oldest first
    bsrm_pkg::result_t reports_due[$];

    int fault_count = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    logic [bsrm_pkg::TIME_W-1:0] t_ms = '0;

    // Moving average step: the move toward the target floors, so a falling
    // level rounds its step magnitude up.
    function automatic logic [bsrm_pkg::LEVEL_OUT_W-1:0] ema_step(
        input logic [bsrm_pkg::LEVEL_OUT_W-1:0] lvl,
        input logic [bsrm_pkg::LEVEL_OUT_W-1:0] tgt,
        input logic [bsrm_pkg::GAIN_W-1:0]      g
    );
        logic [bsrm_pkg::LEVEL_OUT_W-1:0] gap;
        logic [PROD_W-1:0]                prod;
        if (tgt >= lvl) begin
            gap  = tgt - lvl;
            prod = PROD_W'(gap) * PROD_W'(g);
            return lvl + prod[PROD_W-1:bsrm_pkg::GAIN_W];
        end
        gap  = lvl - tgt;
        prod = PROD_W'(gap) * PROD_W'(g) + PROD_W'(16'hFFFF);
        return lvl - prod[PROD_W-1:bsrm_pkg::GAIN_W];
    endfunction

    task automatic reset_monitor_shadow();
        regs.crank_interval_ms  = bsrm_pkg::CRANK_INTERVAL_RST;
        regs.sample_interval_ms = bsrm_pkg::SAMPLE_INTERVAL_RST;
        regs.rest_settle_ms     = bsrm_pkg::REST_SETTLE_RST;
        regs.smoothing_gain     = bsrm_pkg::SMOOTHING_GAIN_RST;
        mon_level         = '0;
        mon_primed        = 1'b0;
        mon_crank_on      = 1'b0;
        mon_crank_low     = '0;
        mon_crank_pub     = '0;
        mon_rest_level    = '0;
        mon_rest_ok       = 1'b0;
        mon_last_sample   = '0;
        mon_last_activity = '0;
    endtask

    // Advance the shadow by one tick and return the report it must produce.
    function automatic bsrm_pkg::result_t advance_monitor(input bsrm_pkg::item_t t);
        logic                             in_crank;
        logic                             quiet;
        logic                             took;
        logic [bsrm_pkg::TIME_W-1:0]      ival;
        logic [bsrm_pkg::TIME_W-1:0]      since;
        logic [bsrm_pkg::LEVEL_OUT_W-1:0] reading;
        bsrm_pkg::result_t                r;
        in_crank = (t.pump_phase == bsrm_pkg::PH_CRANK);
        quiet    = !t.relays_active &&
                   (t.pump_phase == bsrm_pkg::PH_IDLE ||
                    t.pump_phase == bsrm_pkg::PH_UNKNOWN);
        took     = 1'b0;

        // Leaving the crank publishes its minimum ahead of any sampling
        if (mon_crank_on && !in_crank) begin
            mon_crank_on  = 1'b0;
            mon_crank_pub = mon_crank_low;
        end

        ival  = in_crank ? bsrm_pkg::TIME_W'(regs.crank_interval_ms)
                         : bsrm_pkg::TIME_W'(regs.sample_interval_ms);
        since = t.now_ms - mon_last_sample;
        if (since >= ival) begin
            took            = 1'b1;
            mon_last_sample = t.now_ms;
            reading         = bsrm_pkg::LEVEL_OUT_W'(t.adc_sample) << FRAC_W;
            if (!mon_primed) begin
                mon_level  = reading;
                mon_primed = 1'b1;
            end else begin
                mon_level = ema_step(mon_level, reading, regs.smoothing_gain);
            end

            if (in_crank) begin
                if (!mon_crank_on) begin
                    mon_crank_on  = 1'b1;
                    mon_crank_low = t.adc_sample;
                end else if (t.adc_sample < mon_crank_low) begin
                    mon_crank_low = t.adc_sample;
                end
            end

            if (!quiet) begin
                mon_last_activity = t.now_ms;
                mon_rest_ok       = 1'b0;
            end else if (bsrm_pkg::TIME_W'(t.now_ms - mon_last_activity) >=
                         regs.rest_settle_ms) begin
                mon_rest_level = mon_level;
                mon_rest_ok    = 1'b1;
            end
        end

        r.live_level    = mon_level;
        r.crank_minimum = mon_crank_pub;
        r.resting_level = mon_rest_ok ? mon_rest_level : '0;
        r.resting_valid = mon_rest_ok;
        r.sampled       = took;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    function automatic bsrm_pkg::item_t make_tick(
        input logic [bsrm_pkg::TIME_W-1:0]   stamp,
        input logic [bsrm_pkg::PHASE_W-1:0]  phase,
        input logic                          relays,
        input logic [bsrm_pkg::ADC_IN_W-1:0] adc
    );
        bsrm_pkg::item_t t;
        t.now_ms        = stamp;
        t.pump_phase    = phase;
        t.relays_active = relays;
        t.adc_sample    = adc;
        return t;
    endfunction

    // Present one word and hold it until the block takes it; valid stays
    // high afterwards so the next word can follow without a gap.
    task automatic send_tick(input bsrm_pkg::item_t t);
        @(negedge clk);
        item_ch.valid = 1'b1;
        item_ch.data  = t;
        do @(posedge clk); while (!item_ch.ready);
        reports_due.push_back(advance_monitor(t));
    endtask

    // Drop valid for the given number of cycles.
    task automatic pause_sender(input int cycles);
        @(negedge clk);
        item_ch.valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Send in bursts of random length; an occasional long burst gives
    // stretches with no sender idling at all.
    task automatic send_paced(input bsrm_pkg::item_t t);
        if (burst_left == 0) begin
            pause_sender($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        send_tick(t);
    endtask

    // Stop sending and wait until every owed report has come back, then let
    // the pipeline settle.
    task automatic drain_reports();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (reports_due.size() != 0) @(posedge clk);
        repeat (LATENCY_SLACK) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // APB register writes: setup cycle, then access cycle
    // ------------------------------------------------------------------------
    task automatic write_reg(input bsrm_pkg::reg_idx_t idx,
                             input logic [bsrm_pkg::APB_DATA_W-1:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            bsrm_pkg::REG_CRANK_INTERVAL:
                regs.crank_interval_ms  = val[bsrm_pkg::IVAL_W-1:0];
            bsrm_pkg::REG_SAMPLE_INTERVAL:
                regs.sample_interval_ms = val[bsrm_pkg::IVAL_W-1:0];
            bsrm_pkg::REG_REST_SETTLE:
                regs.rest_settle_ms     = val[bsrm_pkg::TIME_W-1:0];
            bsrm_pkg::REG_SMOOTHING_GAIN:
                regs.smoothing_gain     = val[bsrm_pkg::GAIN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_config(
        input logic [bsrm_pkg::IVAL_W-1:0] crank_ms,
        input logic [bsrm_pkg::IVAL_W-1:0] sample_ms,
        input logic [bsrm_pkg::TIME_W-1:0] settle_ms,
        input logic [bsrm_pkg::GAIN_W-1:0] gain
    );
        drain_reports();
        write_reg(bsrm_pkg::REG_CRANK_INTERVAL, bsrm_pkg::APB_DATA_W'(crank_ms));
        write_reg(bsrm_pkg::REG_SAMPLE_INTERVAL, bsrm_pkg::APB_DATA_W'(sample_ms));
        write_reg(bsrm_pkg::REG_REST_SETTLE, bsrm_pkg::APB_DATA_W'(settle_ms));
        write_reg(bsrm_pkg::REG_SMOOTHING_GAIN, bsrm_pkg::APB_DATA_W'(gain));
    endtask

    // ------------------------------------------------------------------------
    // Random pump sessions
    // ------------------------------------------------------------------------

    // Pick the time advance for a tick: mostly around the interval that
    // applies, sometimes just short of it, tiny, a settle-sized jump or a
    // wild jump anywhere in the 32-bit range.
    function automatic logic [bsrm_pkg::TIME_W-1:0] pick_advance(
        input logic [bsrm_pkg::TIME_W-1:0] ival
    );
        int k;
        k = $urandom_range(0, 19);
        if (k < 2)
            return (ival == 0) ? '0 : bsrm_pkg::TIME_W'($urandom_range(0, ival - 1));
        if (k < 12)
            return ival + bsrm_pkg::TIME_W'($urandom_range(0, ival / 4));
        if (k < 15)
            return bsrm_pkg::TIME_W'($urandom_range(0, 3));
        if (k < 17)
            return (ival == 0) ? '0 : ival - 1;
        if (k < 19)
            return regs.rest_settle_ms + bsrm_pkg::TIME_W'($urandom_range(0, 50));
        return bsrm_pkg::TIME_W'($urandom());
    endfunction

    // Mostly well-formed sessions (idle, crank, other and unknown phase runs with a
    // plausible relay pattern), with a share of pure noise ticks. Halfway
    // through, hold the sender until every report has come back.
    task automatic run_sessions(input int count, input int noise_pct);
        segment_t                      seg;
        int                            seg_left;
        int                            relay_pct;
        logic [bsrm_pkg::PHASE_W-1:0]  ph;
        logic [bsrm_pkg::TIME_W-1:0]   ival;
        logic [bsrm_pkg::ADC_IN_W-1:0] adc;
        bsrm_pkg::item_t               t;
        seg      = SEG_IDLE;
        seg_left = 0;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2)
                drain_reports();
            if (seg_left == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: seg = SEG_IDLE;
                    4, 5, 6:    seg = SEG_CRANK;
                    7, 8:       seg = SEG_OTHER;
                    default:    seg = SEG_UNKNOWN;
                endcase
                seg_left = $urandom_range(1, 24);
            end
            seg_left--;
            case (seg)
                SEG_IDLE:  begin ph = bsrm_pkg::PH_IDLE;    relay_pct = 8;  end
                SEG_CRANK: begin ph = bsrm_pkg::PH_CRANK;   relay_pct = 70; end
                SEG_OTHER: begin ph = bsrm_pkg::PH_OTHER;   relay_pct = 50; end
                default:   begin ph = bsrm_pkg::PH_UNKNOWN; relay_pct = 15; end
            endcase
            ival = (ph == bsrm_pkg::PH_CRANK) ? bsrm_pkg::TIME_W'(regs.crank_interval_ms)
                                              : bsrm_pkg::TIME_W'(regs.sample_interval_ms);
            t_ms = t_ms + pick_advance(ival);
            if ($urandom_range(0, 9) == 0)
                adc = $urandom_range(0, 1) ? '1 : '0;
            else
                adc = bsrm_pkg::ADC_IN_W'($urandom_range(0, 4095));
            t = make_tick(t_ms, ph, $urandom_range(0, 99) < relay_pct, adc);
            // Noise tick: any time, any phase, any relay state
            if ($urandom_range(0, 99) < noise_pct)
                t = make_tick(bsrm_pkg::TIME_W'($urandom()),
                              bsrm_pkg::PHASE_W'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)), adc);
            send_paced(t);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Walk the reset settings through first sample, falling average, crank
    // start and minimum, crank end publication, activity, settle reached,
    // and sampling across the 32-bit time wrap.
    task automatic test_directed_ticks();
        send_paced(make_tick(32'd0,     bsrm_pkg::PH_IDLE,    1'b0, 12'hFFF));
        send_paced(make_tick(32'd1999,  bsrm_pkg::PH_IDLE,    1'b0, 12'hFFF));
        send_paced(make_tick(32'd2000,  bsrm_pkg::PH_IDLE,    1'b0, 12'hFFF));
        send_paced(make_tick(32'd4000,  bsrm_pkg::PH_UNKNOWN, 1'b0, 12'h000));
        send_paced(make_tick(32'd6000,  bsrm_pkg::PH_IDLE,    1'b1, 12'd2048));
        send_paced(make_tick(32'd6010,  bsrm_pkg::PH_CRANK,   1'b1, 12'd1500));
        send_paced(make_tick(32'd6020,  bsrm_pkg::PH_CRANK,   1'b1, 12'd1500));
        send_paced(make_tick(32'd6040,  bsrm_pkg::PH_CRANK,   1'b1, 12'd900));
        send_paced(make_tick(32'd6050,  bsrm_pkg::PH_CRANK,   1'b0, 12'h000));
        send_paced(make_tick(32'd6060,  bsrm_pkg::PH_CRANK,   1'b1, 12'hFFF));
        send_paced(make_tick(32'd6061,  bsrm_pkg::PH_OTHER,   1'b0, 12'h000));
        send_paced(make_tick(32'd8061,  bsrm_pkg::PH_OTHER,   1'b0, 12'd1000));
        send_paced(make_tick(32'd68061, bsrm_pkg::PH_IDLE,    1'b0, 12'd3000));
        send_paced(make_tick(32'd70061, bsrm_pkg::PH_IDLE,    1'b1, 12'd3000));
        send_paced(make_tick(32'hFFFF_FF00, bsrm_pkg::PH_IDLE,    1'b0, 12'hFFF));
        send_paced(make_tick(32'hFFFF_FFFF, bsrm_pkg::PH_IDLE,    1'b0, 12'hAAA));
        send_paced(make_tick(32'h0000_0100, bsrm_pkg::PH_IDLE,    1'b0, 12'h555));
        send_paced(make_tick(32'h0000_06D0, bsrm_pkg::PH_UNKNOWN, 1'b0, 12'h555));
        send_paced(make_tick(32'h0000_06E4, bsrm_pkg::PH_CRANK,   1'b1, 12'd10));
        send_paced(make_tick(32'h0000_06F8, bsrm_pkg::PH_CRANK,   1'b0, 12'hFFF));
        send_paced(make_tick(32'h0000_06F9, bsrm_pkg::PH_UNKNOWN, 1'b0, 12'h000));
        t_ms = 32'h0000_06F9;
    endtask

    task automatic test_reset_settings_traffic();
        run_sessions(PHASE_ITEMS, 10);
    endtask

    task automatic test_fastest_sampling();
        apply_config(16'd1, 16'd1, 32'd0, 16'hFFFF);
        run_sessions(PHASE_ITEMS, 10);
    endtask

    task automatic test_slowest_sampling();
        apply_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd0);
        run_sessions(PHASE_ITEMS, 10);
    endtask

    // A zero interval turns every tick into a sampling tick
    task automatic test_zero_intervals();
        apply_config(16'd0, 16'd0, 32'd5, bsrm_pkg::GAIN_W'($urandom_range(0, 65535)));
        run_sessions(PHASE_ITEMS, 10);
    endtask

    task automatic test_typical_settings();
        apply_config(bsrm_pkg::IVAL_W'($urandom_range(1, 100)),
                     bsrm_pkg::IVAL_W'($urandom_range(20, 3000)),
                     bsrm_pkg::TIME_W'($urandom_range(0, 20000)),
                     bsrm_pkg::GAIN_W'($urandom_range(1, 65535)));
        run_sessions(PHASE_ITEMS, 10);
    endtask

    task automatic test_wide_random_settings();
        apply_config(bsrm_pkg::IVAL_W'($urandom_range(0, 65535)),
                     bsrm_pkg::IVAL_W'($urandom_range(0, 65535)),
                     bsrm_pkg::TIME_W'($urandom()),
                     bsrm_pkg::GAIN_W'($urandom_range(0, 65535)));
        run_sessions(PHASE_ITEMS, 15);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: ready follows a pattern (open, coin toss, periodic or burst
    // stall) that is picked anew at random.
    // ------------------------------------------------------------------------
    initial begin
        rx_mode_t mode;
        int       mode_left;
        int       stall_left;
        mode       = RX_OPEN;
        mode_left  = 0;
        stall_left = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (mode_left == 0) begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            case (mode)
                RX_OPEN:     result_ch.ready = 1'b1;
                RX_COIN:     result_ch.ready = 1'($urandom_range(0, 1));
                RX_PERIODIC: result_ch.ready = (mode_left % 5) != 0;
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        result_ch.ready = 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        stall_left      = $urandom_range(1, 10);
                        result_ch.ready = 1'b0;
                    end else begin
                        result_ch.ready = 1'b1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted word with the oldest report owed
    // ------------------------------------------------------------------------
    task automatic check_field(
        input string                       what,
        input logic [bsrm_pkg::TIME_W-1:0] want,
        input logic [bsrm_pkg::TIME_W-1:0] got
    );
        if (want !== got) begin
            fault_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, want, got);
        end
    endtask

    always @(posedge clk) begin
        bsrm_pkg::result_t want;
        bsrm_pkg::result_t got;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.data;
            if (reports_due.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected result word, expected none, actual 0x%0h",
                         $time, got);
            end else begin
                want = reports_due.pop_front();
                check_field("live_level", bsrm_pkg::TIME_W'(want.live_level),
                            bsrm_pkg::TIME_W'(got.live_level));
                check_field("crank_minimum", bsrm_pkg::TIME_W'(want.crank_minimum),
                            bsrm_pkg::TIME_W'(got.crank_minimum));
                check_field("resting_level", bsrm_pkg::TIME_W'(want.resting_level),
                            bsrm_pkg::TIME_W'(got.resting_level));
                check_field("resting_valid", bsrm_pkg::TIME_W'(want.resting_valid),
                            bsrm_pkg::TIME_W'(got.resting_valid));
                check_field("sampled", bsrm_pkg::TIME_W'(want.sampled),
                            bsrm_pkg::TIME_W'(got.sampled));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no word moves on either channel for too long
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d reports outstanding",
                     $time, WATCHDOG_LIMIT, reports_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // Hold every input at a known value before the first edge
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        reset_monitor_shadow();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_ticks();
        test_reset_settings_traffic();
        test_fastest_sampling();
        test_slowest_sampling();
        test_zero_intervals();
        test_typical_settings();
        test_wide_random_settings();

        // Wait out the last reports, then give stray words time to show up
        drain_reports();
        repeat (8) @(posedge clk);

        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
src/bsrm_pkg.sv
src/bsrm_ifs.sv
src/bsrm_cfg.sv
src/bsrm_core.sv
src/battery_sag_and_rest_monitor_unit.sv
tb/sv/testbench.sv
